/* design/piph_pkg.sv */
`default_nettype none
package piph_pkg;
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [15:0] RST_COEFF = 16'd6519;
  localparam logic signed [15:0] RST_LOW_EDGE = -16'sd18432;
  localparam logic [15:0] RST_SCALE = 16'd356;
  localparam logic [1:0] REG_COEFF = 2'd0;
  localparam logic [1:0] REG_LOW_EDGE = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;
  localparam logic OP_POINT = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic signed [39:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] SUM_MIN = 40'sh80_0000_0000;

  function automatic logic [29:0] atan_turns(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0: r = 30'h20000000;  5'd1: r = 30'h12E4051E;  5'd2: r = 30'h09FB385B;
      5'd3: r = 30'h051111D4;  5'd4: r = 30'h028B0D43;  5'd5: r = 30'h0145D7E1;
      5'd6: r = 30'h00A2F61E;  5'd7: r = 30'h00517C55;  5'd8: r = 30'h0028BE53;
      5'd9: r = 30'h00145F2F;  5'd10: r = 30'h000A2F98; 5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6; 5'd13: r = 30'h000145F3; 5'd14: r = 30'h0000A2FA;
      5'd15: r = 30'h0000517D; 5'd16: r = 30'h000028BE; 5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A30; 5'd19: r = 30'h00000518; 5'd20: r = 30'h0000028C;
      5'd21: r = 30'h00000146; 5'd22: r = 30'h000000A3; 5'd23: r = 30'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [18:0] r;
    t = 35'(v) + 35'sd32768;
    r = 19'(t >>> 16);
    if (r > 19'sd16384) r = 19'sd16384;
    if (r < -19'sd16384) r = -19'sd16384;
    return 16'(r);
  endfunction

  function automatic logic signed [39:0] sat_add(input logic signed [39:0] a,
                                                 input logic signed [15:0] w);
    logic signed [40:0] r;
    r = 41'(a) + 41'(w);
    if (r > 41'(SUM_MAX)) r = 41'(SUM_MAX);
    if (r < 41'(SUM_MIN)) r = 41'(SUM_MIN);
    return 40'(r);
  endfunction
endpackage
`default_nettype wire

/* design/piph_ram.sv */
`default_nettype none
module piph_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 50
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/piph_cordic.sv */
`default_nettype none
module piph_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [15:0]        phase,
  output logic                    done,
  output logic signed [15:0]      cos_out,
  output logic signed [15:0]      sin_out
);
  localparam int CW = $clog2(STEPS + 1);
  logic signed [33:0] x, y;
  logic signed [33:0] z;
  logic neg, busy;
  logic [CW-1:0] step;
  logic signed [16:0] a;
  logic signed [15:0] c, s;

  always_comb begin
    a = 17'(signed'(phase));
    if (a > 17'sd16384) a = a - 17'sd32768;
    else if (a < -17'sd16384) a = a + 17'sd32768;
    c = piph_pkg::to_q14(x);
    s = piph_pkg::to_q14(y);
  end

  logic neg_in;
  assign neg_in = (signed'(phase) > 16'sd16384) || (signed'(phase) < -16'sd16384);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= piph_pkg::CORDIC_GAIN;
        y <= '0;
        z <= 34'(a) <<< 16;
        neg <= neg_in;
      end else if (busy) begin
        if (step == CW'(STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
          cos_out <= neg ? -c : c;
          sin_out <= neg ? -s : s;
        end else begin
          if (z >= 0) begin
            x <= x - (y >>> step);
            y <= y + (x >>> step);
            z <= z - 34'(piph_pkg::atan_turns(5'(step)));
          end else begin
            x <= x + (y >>> step);
            y <= y - (x >>> step);
            z <= z + 34'(piph_pkg::atan_turns(5'(step)));
          end
          step <= step + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* design/path_integral_phase_histogram.sv */
// path point: states S_MUL and S_ACC, no result; read: S_READ loads the result
// registers; last point: S_MUL, S_ACC, the iterative cordic unit in S_CORD and
// the read-modify-write of the bin memory in S_RMW; one item at a time
// reset: config to defaults, path state to zero, then a clearing pass over all
// BINS entries of the bin memory during which no item is accepted
`default_nettype none
module path_integral_phase_histogram #(
  parameter int BINS = 50,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic signed [15:0] coordinate,
  input  wire logic               last_point,
  input  wire logic [5:0]         read_bin,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    kind,
  output logic signed [15:0]      weight_real,
  output logic signed [15:0]      weight_imag,
  output logic [5:0]              sample_bin,
  output logic                    in_range,
  output logic signed [39:0]      sum_real,
  output logic signed [39:0]      sum_imag
);
  localparam int AW = $clog2(BINS);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_MUL   = 8'b00000100,
    S_ACC   = 8'b00001000,
    S_CORD  = 8'b00010000,
    S_RMW   = 8'b00100000,
    S_READ  = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;
  state_t state;

  // configuration registers
  logic [15:0] phase_coeff, bin_scale;
  logic signed [15:0] hist_low_edge;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_coeff <= piph_pkg::RST_COEFF;
      hist_low_edge <= piph_pkg::RST_LOW_EDGE;
      bin_scale <= piph_pkg::RST_SCALE;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        piph_pkg::REG_COEFF: phase_coeff <= pwdata[15:0];
        piph_pkg::REG_LOW_EDGE: hist_low_edge <= pwdata[15:0];
        piph_pkg::REG_SCALE: bin_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      piph_pkg::REG_COEFF: prdata = {16'd0, phase_coeff};
      piph_pkg::REG_LOW_EDGE: prdata = {16'd0, hist_low_edge};
      piph_pkg::REG_SCALE: prdata = {16'd0, bin_scale};
      default: prdata = '0;
    endcase
  end

  // path state and captured transaction
  logic signed [15:0] prev_coord, coord_q;
  logic [15:0] phase;
  logic [15:0] phase_next;
  logic last_q;
  logic signed [16:0] delta;
  logic [33:0] dsq;
  logic [49:0] prod;
  logic [AW-1:0] clr_addr, bin_q;
  logic hit_q;
  logic [5:0] rbin_q;

  // histogram memory: real sum in the upper half, imaginary in the lower
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [79:0] ram_wdata, ram_rdata;
  piph_ram #(.WIDTH(80), .DEPTH(BINS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // the cordic starts from the phase that includes the final step
  logic cord_start, cord_done;
  logic signed [15:0] cos_w, sin_w;
  piph_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .phase(phase_next),
    .done(cord_done), .cos_out(cos_w), .sin_out(sin_w)
  );

  // binning of the final coordinate
  logic signed [16:0] offset;
  logic [32:0] bprod;
  logic [14:0] bin_full;
  assign offset = 17'(coord_q) - 17'(hist_low_edge);
  assign bprod = 33'(offset[15:0]) * 33'(bin_scale);
  assign bin_full = bprod[32:18];

  logic accept;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;
  assign cord_start = (state == S_ACC) && last_q;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = bin_q;
    ram_wdata = {piph_pkg::sat_add(signed'(ram_rdata[79:40]), weight_real),
                 piph_pkg::sat_add(signed'(ram_rdata[39:0]), weight_imag)};
    ram_raddr = bin_q;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_RMW) begin
      ram_we = hit_q;
    end
    if (state == S_IDLE) ram_raddr = AW'(read_bin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      prev_coord <= '0;
      phase <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(BINS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          coord_q <= coordinate;
          last_q <= last_point;
          rbin_q <= read_bin;
          delta <= 17'(coordinate) - 17'(prev_coord);
          state <= (opcode == piph_pkg::OP_READ) ? S_READ : S_MUL;
        end
        S_MUL: begin
          dsq <= 34'(delta * delta);
          state <= S_ACC;
        end
        S_ACC: begin
          // coeff times squared step, in 2^-36 turn, truncated to 2^-16
          phase <= phase_next;
          prev_coord <= coord_q;
          hit_q <= !offset[16] && (bin_full < 15'(BINS));
          bin_q <= AW'(bin_full);
          state <= last_q ? S_CORD : S_IDLE;
        end
        S_CORD: if (cord_done) begin
          kind <= 1'b0;
          weight_real <= cos_w;
          weight_imag <= sin_w;
          sample_bin <= hit_q ? 6'(bin_q) : 6'd0;
          in_range <= hit_q;
          sum_real <= '0;
          sum_imag <= '0;
          state <= S_RMW;
        end
        S_RMW: begin
          // read data of bin_q valid now; write back if in range and show the weight
          out_valid <= 1'b1;
          prev_coord <= '0;
          phase <= '0;
          state <= S_IDLE;
        end
        S_READ: begin
          kind <= 1'b1;
          weight_real <= '0;
          weight_imag <= '0;
          sample_bin <= '0;
          in_range <= 1'b0;
          sum_real <= (7'(rbin_q) < 7'(BINS)) ? signed'(ram_rdata[79:40]) : '0;
          sum_imag <= (7'(rbin_q) < 7'(BINS)) ? signed'(ram_rdata[39:0]) : '0;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  assign prod = 50'(phase_coeff) * 50'(dsq);
  assign phase_next = phase + prod[35:20];
endmodule
`default_nettype wire

/* test/phase_histogram_checker.sv */
`default_nettype none
module phase_histogram_checker #(
  parameter int BINS = 50,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               opcode,
  input  wire logic signed [15:0] coordinate,
  input  wire logic               last_point,
  input  wire logic [5:0]         read_bin,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               kind,
  input  wire logic signed [15:0] weight_real,
  input  wire logic signed [15:0] weight_imag,
  input  wire logic [5:0]         sample_bin,
  input  wire logic               in_range,
  input  wire logic signed [39:0] sum_real,
  input  wire logic signed [39:0] sum_imag,
  output int                      mismatches,
  output int                      pending
);
  typedef struct packed {
    logic               kind;
    logic signed [15:0] wr;
    logic signed [15:0] wi;
    logic [5:0]         bin;
    logic               rng;
    logic signed [39:0] sr;
    logic signed [39:0] si;
  } weight_result_t;

  weight_result_t     expected_results[$];
  logic [15:0]        coeff;
  logic signed [15:0] low_edge;
  logic [15:0]        scale;
  logic signed [15:0] prev_coord;
  logic [15:0]        phase;
  logic signed [39:0] real_sums [BINS];
  logic signed [39:0] imag_sums [BINS];

  assign pending = expected_results.size();

  function automatic logic signed [63:0] ashr(input logic signed [63:0] v, input int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] round_q14(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return 16'(r);
  endfunction

  // fold into a quarter turn, rotate, round
  task automatic rotate_phase(input logic [15:0] ph, output logic signed [15:0] c,
                              output logic signed [15:0] s);
    int                 a;
    bit                 neg;
    logic signed [63:0] x, y, z, dx, dy, atn;
    a = $signed(ph);
    neg = 0;
    if (a > 16384) begin
      a -= 32768; neg = 1;
    end else if (a < -16384) begin
      a += 32768; neg = 1;
    end
    x = 64'sd652032874;
    y = 0;
    z = 64'(a) * 64'sd65536;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = ashr(y, i);
      dy = ashr(x, i);
      atn = 64'(atan_lut(i));
      if (z >= 0) begin
        x -= dx; y += dy; z -= atn;
      end else begin
        x += dx; y -= dy; z += atn;
      end
    end
    c = round_q14(x);
    s = round_q14(y);
    if (neg) begin
      c = -c; s = -s;
    end
  endtask

  function automatic logic [29:0] atan_lut(input int i);
    logic [29:0] t [24] = '{30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
      30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53,
      30'h00145F2F, 30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3,
      30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30,
      30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051};
    return t[i];
  endfunction

  function automatic logic signed [39:0] add_clamped(input logic signed [39:0] acc,
                                                     input logic signed [15:0] w);
    logic signed [41:0] r;
    r = 42'(acc) + 42'(w);
    if (r > 42'sh7F_FFFF_FFFF) r = 42'sh7F_FFFF_FFFF;
    if (r < -42'sh80_0000_0000) r = -42'sh80_0000_0000;
    return 40'(r);
  endfunction

  task automatic predict_transaction();
    weight_result_t     e;
    logic signed [16:0] d;
    logic [33:0]        d2;
    logic [63:0]        inc;
    logic signed [16:0] offs;
    logic [63:0]        b;
    e = '0;
    if (opcode == piph_pkg::OP_READ) begin
      e.kind = 1'b1;
      if (read_bin < BINS) begin
        e.sr = real_sums[read_bin];
        e.si = imag_sums[read_bin];
      end
      expected_results.push_back(e);
      return;
    end
    d = 17'(coordinate) - 17'(prev_coord);
    d2 = 34'($signed(d) * $signed(d));
    inc = (64'(coeff) * 64'(d2)) >> 20;
    phase = phase + inc[15:0];
    prev_coord = coordinate;
    if (!last_point) return;
    rotate_phase(phase, e.wr, e.wi);
    offs = 17'(coordinate) - 17'(low_edge);
    if (offs >= 0) begin
      b = (64'(offs) * 64'(scale)) >> 18;
      if (b < BINS) begin
        real_sums[b] = add_clamped(real_sums[b], e.wr);
        imag_sums[b] = add_clamped(imag_sums[b], e.wi);
        e.bin = b[5:0];
        e.rng = 1'b1;
      end
    end
    prev_coord = '0;
    phase = '0;
    expected_results.push_back(e);
  endtask

  always @(posedge clk) begin
    weight_result_t e;
    if (rst) begin
      coeff <= piph_pkg::RST_COEFF;
      low_edge <= piph_pkg::RST_LOW_EDGE;
      scale <= piph_pkg::RST_SCALE;
      prev_coord <= '0;
      phase <= '0;
      for (int i = 0; i < BINS; i++) begin
        real_sums[i] = '0;
        imag_sums[i] = '0;
      end
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          piph_pkg::REG_COEFF: coeff = pwdata[15:0];
          piph_pkg::REG_LOW_EDGE: low_edge = pwdata[15:0];
          piph_pkg::REG_SCALE: scale = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_transaction();
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transaction");
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          if (e != {kind, weight_real, weight_imag, sample_bin, in_range, sum_real,
                    sum_imag}) begin
            if (mismatches < 10)
              $display("mismatch: exp k%0d w(%0d,%0d) b%0d r%0d s(%0d,%0d) got k%0d"
                       , e.kind, e.wr, e.wi, e.bin, e.rng, e.sr, e.si, kind,
                       " w(%0d,%0d) b%0d r%0d s(%0d,%0d)", weight_real, weight_imag,
                       sample_bin, in_range, sum_real, sum_imag);
            mismatches++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* test/tb.sv */
`default_nettype none
module tb;
  logic               clk = 0;
  logic               rst = 1;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 0;
  logic               in_stall;
  logic               opcode = 0;
  logic signed [15:0] coordinate = '0;
  logic               last_point = 0;
  logic [5:0]         read_bin = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               kind, in_range;
  logic signed [15:0] weight_real, weight_imag;
  logic [5:0]         sample_bin;
  logic signed [39:0] sum_real, sum_imag;
  int                 mismatches, pending;
  int                 cycles = 0;
  bit                 long_hold = 0;
  bit                 sink_random = 1;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  path_integral_phase_histogram uut (.*);
  phase_histogram_checker chk (.*);

  // watchdog over the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("path_integral_phase_histogram test failed");
      $finish;
    end
  end

  // receiver: random stall, mostly short, sometimes long; long hold on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1;
      end else if (sink_random && $urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_stall <= 1;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= {16'(0), v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // one transaction, held until accepted
  task automatic send_item(input logic op, input logic signed [15:0] c, input logic lp,
                           input logic [5:0] rb, input bit gaps);
    int g;
    in_valid <= 1; opcode <= op; coordinate <= c; last_point <= lp; read_bin <= rb;
    do @(posedge clk); while (in_stall);
    if (gaps && $urandom_range(0, 2) == 0) begin
      g = ($urandom_range(0, 20) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // idle the item channel until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return 16'sh7FFF;
      2: return -16'sh8000;
      default: return 16'($signed($urandom_range(0, 40960)) - 20480);
    endcase
  endfunction

  task automatic random_phase(input int items);
    int k, len;
    k = 0;
    while (k < items) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(piph_pkg::OP_READ, 16'($urandom()), 0, 6'($urandom()), 1);
        k++;
      end else begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          send_item(piph_pkg::OP_POINT, rand_coord(), j == len - 1, 6'($urandom()), 1);
          k++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, short paths, reads in and beyond range
    send_item(piph_pkg::OP_READ, 0, 0, 0, 0);
    send_item(piph_pkg::OP_POINT, 0, 1, 0, 0);
    send_item(piph_pkg::OP_POINT, 16'sh7FFF, 0, 0, 0);
    send_item(piph_pkg::OP_POINT, -16'sh8000, 0, 0, 0);
    send_item(piph_pkg::OP_POINT, 16'sh7FFF, 1, 0, 0);
    send_item(piph_pkg::OP_POINT, -16'sd18432, 1, 0, 0);
    send_item(piph_pkg::OP_POINT, -16'sd18433, 1, 0, 0);
    send_item(piph_pkg::OP_POINT, 16'sd1024, 0, 0, 0);
    send_item(piph_pkg::OP_POINT, 16'sd3000, 1, 6'h3F, 0);
    send_item(piph_pkg::OP_POINT, 16'sd18000, 1, 0, 0);
    send_item(piph_pkg::OP_READ, 16'hFFFF, 1, 6'd0, 0);
    send_item(piph_pkg::OP_READ, 0, 0, 6'd49, 0);
    send_item(piph_pkg::OP_READ, 0, 0, 6'd50, 0);
    send_item(piph_pkg::OP_READ, 0, 0, 6'd63, 0);
    drain();

    // settings sweep, extremes among them
    reg_write(piph_pkg::REG_COEFF, 16'hFFFF);
    reg_write(piph_pkg::REG_LOW_EDGE, 16'h8000);
    reg_write(piph_pkg::REG_SCALE, 16'hFFFF);
    random_phase(150);
    drain();
    reg_write(piph_pkg::REG_COEFF, 16'h0000);
    reg_write(piph_pkg::REG_LOW_EDGE, 16'h7FFF);
    reg_write(piph_pkg::REG_SCALE, 16'h0001);
    send_item(piph_pkg::OP_POINT, 16'sh7FFF, 1, 0, 0);
    send_item(piph_pkg::OP_READ, 0, 0, 0, 0);
    random_phase(100);
    drain();
    reg_write(piph_pkg::REG_COEFF, 16'($urandom()));
    reg_write(piph_pkg::REG_LOW_EDGE, 16'($signed($urandom_range(0, 8192)) - 20000));
    reg_write(piph_pkg::REG_SCALE, 16'($urandom_range(100, 800)));
    random_phase(200);

    // receiver holds off while items keep coming
    long_hold <= 1;
    fork
      begin
        repeat (400) @(posedge clk);
        long_hold <= 0;
      end
      random_phase(40);
    join
    drain();

    reg_write(piph_pkg::REG_COEFF, 16'd6519);
    reg_write(piph_pkg::REG_LOW_EDGE, -16'sd18432);
    reg_write(piph_pkg::REG_SCALE, 16'd356);
    random_phase(200);
    drain();
    reg_write(piph_pkg::REG_COEFF, 16'($urandom()));
    reg_write(piph_pkg::REG_SCALE, 16'($urandom_range(1, 65535)));
    sink_random <= 0;
    random_phase(150);
    for (int b = 0; b < 64; b++) send_item(piph_pkg::OP_READ, 0, 0, 6'(b), 1);
    drain();

    if (mismatches == 0)
      $display("path_integral_phase_histogram test passed");
    else
      $display("path_integral_phase_histogram test failed");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
design/piph_pkg.sv
design/piph_ram.sv
design/piph_cordic.sv
design/path_integral_phase_histogram.sv
test/phase_histogram_checker.sv
test/tb.sv
